// File: hdl/sql_named_param_rewriter_macros.svh
// assertion macros shared by the rewriter checker
// each macro expects clk and rst_n to be visible where it is used
`ifndef SQL_NAMED_PARAM_REWRITER_MACROS_SVH
`define SQL_NAMED_PARAM_REWRITER_MACROS_SVH

// a stalled transfer keeps valid high and the payload unchanged
`define SNPR_ASSERT_STABLE(lbl, vld, rdy, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> (vld && $stable(sig))) else $error("snpr: stalled payload moved");

// same-cycle implication outside reset
`define SNPR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (ante) |-> (cons)) else $error("snpr: implication failed");

// signal is low in the cycle after a reset cycle
`define SNPR_ASSERT_LOW_AFTER_RESET(lbl, sig) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> !(sig)) \
    else $error("snpr: signal high after reset");

`endif

// File: hdl/snpr_pkg.sv
// package for the sql named parameter rewriter: payload types, queue entry
// and character constants; no dependencies
`timescale 1ns / 1ps

package snpr_pkg;

  // input transfer payload
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_t;

  // output transfer payload
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_text;
  } out_t;

  // one queue entry: results of one input byte, one or two
  typedef struct packed {
    out_t res0;
    out_t res1;
    logic two;
  } entry_t;

  // queue status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // characters the scanner reacts to
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  // letter, digit or underscore
  function automatic logic is_name(input logic [7:0] b);
    is_name = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
              (b >= 8'h30 && b <= 8'h39) || (b == CH_UNDER);
  endfunction

endpackage

// File: hdl/snpr_front.sv
// front scanner: tracks the lexical mode and turns each input byte into a
// queue entry of one or two results; uses snpr_pkg
`timescale 1ns / 1ps

module snpr_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  snpr_pkg::in_t    in_data,
  output logic             push,
  output snpr_pkg::entry_t entry
);

  typedef enum logic [3:0] {
    M_NORMAL = 4'd0,
    M_SQ     = 4'd1,
    M_SQ_END = 4'd2,
    M_DQ     = 4'd3,
    M_DQ_END = 4'd4,
    M_LINE   = 4'd5,
    M_BLOCK  = 4'd6,
    M_BSTAR  = 4'd7,
    M_PARAM  = 4'd8,
    M_PDASH  = 4'd9,
    M_PSLASH = 4'd10,
    M_PCOLON = 4'd11
  } mode_t;

  mode_t mode_r, mode_nxt;

  logic [7:0] b;
  logic       last;
  logic       norm_put;
  mode_t      norm_mode;
  logic       use_norm;
  logic       pre_put, main_put;
  logic [7:0] pre_byte, main_byte;
  mode_t      dir_mode;
  mode_t      scan_mode;

  assign b    = in_data.in_byte;
  assign last = in_data.end_of_text;

  // normal-text classification of the current byte
  always_comb begin
    norm_put  = 1'b1;
    norm_mode = M_NORMAL;
    if (b == snpr_pkg::CH_SQUOTE) begin
      norm_mode = M_SQ;
    end else if (b == snpr_pkg::CH_DQUOTE) begin
      norm_mode = M_DQ;
    end else if (b == snpr_pkg::CH_DASH || b == snpr_pkg::CH_SLASH ||
                 b == snpr_pkg::CH_COLON) begin
      if (!last) begin
        norm_put = 1'b0;
        if (b == snpr_pkg::CH_DASH) begin
          norm_mode = M_PDASH;
        end else if (b == snpr_pkg::CH_SLASH) begin
          norm_mode = M_PSLASH;
        end else begin
          norm_mode = M_PCOLON;
        end
      end
    end
  end

  // per-mode decisions: an optional held byte first, then the byte itself
  always_comb begin
    use_norm  = 1'b0;
    pre_put   = 1'b0;
    pre_byte  = snpr_pkg::CH_COLON;
    main_put  = 1'b1;
    main_byte = b;
    dir_mode  = mode_r;
    case (mode_r)
      M_SQ: begin
        dir_mode = (b == snpr_pkg::CH_SQUOTE) ? M_SQ_END : M_SQ;
      end
      M_SQ_END: begin
        if (b == snpr_pkg::CH_SQUOTE) dir_mode = M_SQ;
        else use_norm = 1'b1;
      end
      M_DQ: begin
        dir_mode = (b == snpr_pkg::CH_DQUOTE) ? M_DQ_END : M_DQ;
      end
      M_DQ_END: begin
        if (b == snpr_pkg::CH_DQUOTE) dir_mode = M_DQ;
        else use_norm = 1'b1;
      end
      M_LINE: begin
        dir_mode = (b == snpr_pkg::CH_NL) ? M_NORMAL : M_LINE;
      end
      M_BLOCK: begin
        dir_mode = (b == snpr_pkg::CH_STAR) ? M_BSTAR : M_BLOCK;
      end
      M_BSTAR: begin
        if (b == snpr_pkg::CH_SLASH) dir_mode = M_NORMAL;
        else dir_mode = (b == snpr_pkg::CH_STAR) ? M_BSTAR : M_BLOCK;
      end
      M_PARAM: begin
        if (snpr_pkg::is_name(b)) begin
          main_put = 1'b0;
          dir_mode = M_PARAM;
        end else begin
          use_norm = 1'b1;
        end
      end
      M_PDASH: begin
        pre_put  = 1'b1;
        pre_byte = snpr_pkg::CH_DASH;
        if (b == snpr_pkg::CH_DASH) dir_mode = M_LINE;
        else use_norm = 1'b1;
      end
      M_PSLASH: begin
        pre_put  = 1'b1;
        pre_byte = snpr_pkg::CH_SLASH;
        if (b == snpr_pkg::CH_STAR) dir_mode = M_BLOCK;
        else use_norm = 1'b1;
      end
      M_PCOLON: begin
        if (b == snpr_pkg::CH_COLON) begin
          pre_put  = 1'b1;
          dir_mode = M_NORMAL;
        end else if (snpr_pkg::is_name(b)) begin
          main_byte = snpr_pkg::CH_QMARK;
          dir_mode  = M_PARAM;
        end else begin
          pre_put  = 1'b1;
          use_norm = 1'b1;
        end
      end
      default: begin
        use_norm = 1'b1;
      end
    endcase
    if (use_norm) begin
      main_put = norm_put;
    end
  end

  assign scan_mode = use_norm ? norm_mode : dir_mode;
  assign mode_nxt  = last ? M_NORMAL : scan_mode;

  // build the queue entry; a last byte with no output gives a bare end marker
  always_comb begin
    entry.two              = pre_put && main_put;
    entry.res0.out_byte    = pre_put ? pre_byte : main_byte;
    entry.res0.byte_valid  = pre_put || main_put;
    entry.res0.last_of_text = last && !(pre_put && main_put);
    entry.res1.out_byte    = main_byte;
    entry.res1.byte_valid  = 1'b1;
    entry.res1.last_of_text = last;
    if (!pre_put && !main_put) begin
      entry.res0.out_byte = 8'd0;
    end
  end

  assign push = acc && (pre_put || main_put || last);

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_NORMAL;
    end else if (acc) begin
      mode_r <= mode_nxt;
    end
  end

endmodule

// File: hdl/snpr_queue.sv
// short entry queue between scanner and emitter; uses snpr_pkg
// depth comes from the top level
`timescale 1ns / 1ps

module snpr_queue #(
  parameter int QDEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  snpr_pkg::entry_t  wr_entry,
  input  logic              pop,
  output snpr_pkg::entry_t  head,
  output snpr_pkg::q_stat_t stat
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);
  localparam logic [PW-1:0] PLAST = PW'(QDEPTH - 1);
  localparam logic [CW-1:0] CFULL = CW'(QDEPTH);

  snpr_pkg::entry_t slot_r [QDEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CFULL);
  assign head       = slot_r[rp_r];

  // pointer and fill count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = (wp_r == PLAST) ? '0 : wp_r + PW'(1);
    if (pop)  rp_nxt = (rp_r == PLAST) ? '0 : rp_r + PW'(1);
    if (push && !pop) cnt_nxt = cnt_r + CW'(1);
    else if (!push && pop) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= wr_entry;
    end
  end

endmodule

// File: hdl/snpr_back.sv
// back emitter: walks the one or two results of the head queue entry and
// presents them on the output channel; uses snpr_pkg
`timescale 1ns / 1ps

module snpr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  snpr_pkg::entry_t  head,
  input  snpr_pkg::q_stat_t stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output snpr_pkg::out_t    out_data
);

  logic sel_r, sel_nxt;
  logic xfer;

  assign out_valid = !stat.empty;
  assign out_data  = sel_r ? head.res1 : head.res0;
  assign xfer      = out_valid && out_ready;
  assign pop       = xfer && (sel_r || !head.two);

  // result select within the head entry
  always_comb begin
    sel_nxt = sel_r;
    if (pop) sel_nxt = 1'b0;
    else if (xfer) sel_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

endmodule

// File: hdl/sql_named_param_rewriter.sv
// SQL named parameter rewriter. Takes one byte of SQL text per transfer and
// rewrites each named parameter (a colon and a name of letters, digits and
// underscores) as a single '?', leaving quoted strings, comments and '::'
// casts untouched. A held '-', '/' or ':' comes out one byte later, once the
// next byte settles it; a byte marked end_of_text flushes it and returns the
// scanner to normal text, and if that byte yields nothing a bare end marker
// (byte_valid 0) carries last_of_text. Input is taken every cycle; most bytes
// give one result, which is written into the entry queue and leaves from its
// head. A byte that yields two results (a flushed held byte plus the new
// one, or '::') holds the output while both are sent, which the QDEPTH-entry
// queue between scanner and emitter absorbs; input stalls only when full.
`timescale 1ns / 1ps

module sql_named_param_rewriter #(
  parameter int QDEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  snpr_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output snpr_pkg::out_t out_data
);

  snpr_pkg::entry_t  entry;
  snpr_pkg::entry_t  head;
  snpr_pkg::q_stat_t stat;
  logic              acc;
  logic              push;
  logic              pop;

  assign in_ready = !stat.full;
  assign acc      = in_valid && in_ready;

  // scanner
  snpr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_data (in_data),
    .push    (push),
    .entry   (entry)
  );

  // entry queue
  snpr_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (entry),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  // emitter
  snpr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: hdl/snpr_checker.sv
// port-level checks for the rewriter, bound into the top level
// depends on snpr_pkg and sql_named_param_rewriter_macros.svh
`timescale 1ns / 1ps
`include "sql_named_param_rewriter_macros.svh"

module snpr_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input snpr_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input snpr_pkg::out_t out_data
);

  // a stalled input transfer holds
  `SNPR_ASSERT_STABLE(a_in_hold, in_valid, in_ready, in_data)
  // a stalled result holds
  `SNPR_ASSERT_STABLE(a_out_hold, out_valid, out_ready, out_data)
  // a bare end marker always closes the statement and carries a zero byte
  `SNPR_ASSERT_IMPL(a_marker_last, out_valid && !out_data.byte_valid, out_data.last_of_text && out_data.out_byte == 8'd0)
  // nothing leaves right after reset
  `SNPR_ASSERT_LOW_AFTER_RESET(a_rst_out, out_valid)
  // input is open right after reset
  `SNPR_ASSERT_LOW_AFTER_RESET(a_rst_in, !in_ready)

endmodule

bind sql_named_param_rewriter snpr_checker u_snpr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
